FILE: rtl/ersd_pkg.sv
package ersd_pkg;

  // Partial-product digit width of the pipelined multipliers
  localparam int CHUNK = 16;

  // Default coordinate width (fixed point, shared by inputs and distance)
  localparam int COORD_WIDTH_DEF = 24;

  typedef logic [1:0] status_t;

  // Result status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_DEGEN  = 2'd1;
  localparam status_t ST_CENTRE = 2'd2;

  // Side information that rides along with the distance search
  typedef struct packed {
    logic    neg;
    status_t status;
  } flag_t;

endpackage

FILE: rtl/ersd_if.sv
// Query channel: ellipse centre, basis vectors and point
interface ersd_in_if #(parameter int W = ersd_pkg::COORD_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] centre_x;
  logic signed [W-1:0] centre_y;
  logic signed [W-1:0] major_x;
  logic signed [W-1:0] major_y;
  logic signed [W-1:0] minor_x;
  logic signed [W-1:0] minor_y;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;

  modport source(output valid, centre_x, centre_y, major_x, major_y, minor_x, minor_y,
                 point_x, point_y, input ready);
  modport sink(input valid, centre_x, centre_y, major_x, major_y, minor_x, minor_y,
               point_x, point_y, output ready);
endinterface

// Result channel: signed distance and status
interface ersd_out_if #(parameter int W = ersd_pkg::COORD_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] distance;
  logic [1:0]          status;

  modport source(output valid, distance, status, input ready);
  modport sink(input valid, distance, status, output ready);
endinterface

FILE: rtl/ersd_dly.sv
module ersd_dly #(
  parameter int DW = 1,
  parameter int N  = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] d,
  output logic [DW-1:0] q
);

  // Alignment line: N registers, moving only with the pipeline enable
  if (N == 0) begin : g_none
    assign q = d;
  end else begin : g_line
    logic [DW-1:0] tap_r [N];

    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[0] <= d;
        for (int i = 1; i < N; i++) begin
          tap_r[i] <= tap_r[i-1];
        end
      end
    end

    assign q = tap_r[N-1];
  end

endmodule

FILE: rtl/ersd_mul.sv
module ersd_mul #(
  parameter int AW = 25,
  parameter int BW = 24
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import ersd_pkg::*;

  // One CHUNK-bit digit of b per stage, lowest first; top digit is signed
  localparam int NCH  = (BW + CHUNK - 1) / CHUNK;
  localparam int BPW  = NCH * CHUNK;
  localparam int ACCW = AW + BPW + 1;

  logic signed [AW-1:0]   a_r   [NCH];
  logic signed [BPW-1:0]  b_r   [NCH];
  logic signed [ACCW-1:0] acc_r [NCH];
  logic signed [BPW-1:0]  bx;

  assign bx = BPW'(b);

  for (genvar k = 0; k < NCH; k++) begin : g_st
    logic signed [AW-1:0]    a_in;
    logic signed [BPW-1:0]   b_in;
    logic signed [ACCW-1:0]  acc_in;
    logic signed [CHUNK:0]   dig;
    logic signed [AW+CHUNK:0] pp;

    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = bx;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    if (k == NCH - 1) begin : g_top
      assign dig = {b_in[BPW-1], b_in[CHUNK*k +: CHUNK]};
    end else begin : g_low
      assign dig = {1'b0, b_in[CHUNK*k +: CHUNK]};
    end

    // Partial product, shifted into place and accumulated
    assign pp = a_in * dig;

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k]   <= a_in;
        b_r[k]   <= b_in;
        acc_r[k] <= acc_in + (ACCW'(pp) <<< (CHUNK * k));
      end
    end
  end

  assign p = acc_r[NCH-1][AW+BW-1:0];

endmodule

FILE: rtl/ersd_srch.sv
module ersd_srch #(
  parameter int W   = 24,
  parameter int GSW = 150,
  parameter int M2W = 204
) (
  input  logic             clk,
  input  logic             en,
  input  logic [M2W-1:0]   mag2,
  input  logic [GSW-1:0]   gsq,
  input  ersd_pkg::flag_t  flag_i,
  output logic [W-1:0]     mag_k,
  output ersd_pkg::flag_t  flag_o
);
  import ersd_pkg::*;

  // Sum width: holds t^2*gsq and every partial term for t below 2^W
  localparam int SW = ((M2W > 2*W + GSW + 2) ? M2W : 2*W + GSW + 2) + 2;
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

  // Per stage: acc = t^2*gsq, lin = t*gsq with t = 2k-1
  logic signed [SW-1:0] acc_r [W];
  logic signed [SW-1:0] lin_r [W];
  logic [W-1:0]         k_r   [W];
  logic [M2W-1:0]       m2_r  [W];
  logic [GSW-1:0]       g_r   [W];
  flag_t                fl_r  [W];

  // One result bit per stage, most significant first
  for (genvar s = 0; s < W; s++) begin : g_bit
    localparam int J = W - 1 - s;
    logic signed [SW-1:0] acc_in;
    logic signed [SW-1:0] lin_in;
    logic [W-1:0]         k_in;
    logic [M2W-1:0]       m2_in;
    logic [GSW-1:0]       g_in;
    flag_t                fl_in;
    logic signed [SW-1:0] gx;
    logic signed [SW-1:0] lhs;
    logic [W-1:0]         cand;
    logic [W-1:0]         hi;
    logic                 take;

    if (s == 0) begin : g_first
      assign acc_in = $signed(SW'(gsq));
      assign lin_in = -$signed(SW'(gsq));
      assign k_in   = '0;
      assign m2_in  = mag2;
      assign g_in   = gsq;
      assign fl_in  = flag_i;
    end else begin : g_next
      assign acc_in = acc_r[s-1];
      assign lin_in = lin_r[s-1];
      assign k_in   = k_r[s-1];
      assign m2_in  = m2_r[s-1];
      assign g_in   = g_r[s-1];
      assign fl_in  = fl_r[s-1];
    end

    // (t + 2^(J+1))^2 * gsq from the running terms
    assign gx   = $signed(SW'(g_in));
    assign lhs  = acc_in + (lin_in <<< (J + 2)) + (gx <<< (2*J + 2));
    assign cand = k_in | (W'(1) << J);
    assign hi   = fl_in.neg ? HALF : HALF - W'(1);
    assign take = (cand <= hi) && (lhs <= $signed(SW'(m2_in)));

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[s] <= take ? lhs : acc_in;
        lin_r[s] <= take ? lin_in + (gx <<< (J + 1)) : lin_in;
        k_r[s]   <= take ? cand : k_in;
        m2_r[s]  <= m2_in;
        g_r[s]   <= g_in;
        fl_r[s]  <= fl_in;
      end
    end
  end

  assign mag_k  = k_r[W-1];
  assign flag_o = fl_r[W-1];

endmodule

FILE: rtl/ellipse_ring_signed_distance_core.sv
// Throughput: one word per cycle while the output skid entry is free; an occupied
//   skid entry stops the pipeline. Set by the 16-bit-digit multiplier stages and
//   the one-bit-per-stage rounding search, all fully pipelined.
// Reset: synchronous, active low; clears the stage valid bits and the output buffer.
module ellipse_ring_signed_distance_core #(
  parameter int COORD_WIDTH = ersd_pkg::COORD_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ersd_in_if.sink    in_ch,
  ersd_out_if.source out_ch
);
  import ersd_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int CW  = W + 1;          // point minus centre
  localparam int QW  = 2*W + 2;        // determinant, unit-space point
  localparam int GW  = QW + W + 1;     // gradient
  localparam int NW  = 2*QW + 2;       // implicit value numerator
  localparam int GSW = 2*GW;           // squared gradient length
  localparam int M2W = 2*NW;           // squared numerator
  localparam int L1  = (W + CHUNK - 1) / CHUNK;
  localparam int L3  = (QW + CHUNK - 1) / CHUNK;
  localparam int L4  = (NW + CHUNK - 1) / CHUNK;
  localparam int L5  = (GW + CHUNK - 1) / CHUNK;
  localparam int TOT = L1 + L3 + L4 + W + 4;
  localparam int FW  = $bits(flag_t);

  logic en;
  logic out_v_r, skid_v_r;
  logic [TOT:1] vld_r;

  // Global advance: stops only when the skid entry is occupied
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-1:1], in_ch.valid};
    end
  end

  // Stage 1: capture basis, form point offset
  logic signed [W-1:0]  ux_r, uy_r, vx_r, vy_r;
  logic signed [CW-1:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r <= in_ch.major_x;
      uy_r <= in_ch.major_y;
      vx_r <= in_ch.minor_x;
      vy_r <= in_ch.minor_y;
      dx_r <= CW'(in_ch.point_x) - CW'(in_ch.centre_x);
      dy_r <= CW'(in_ch.point_y) - CW'(in_ch.centre_y);
    end
  end

  // Determinant and unit-space point products
  logic signed [CW+W-1:0] p_uv, p_vu, p_vydx, p_vxdy, p_uxdy, p_uydx;

  ersd_mul #(.AW(CW), .BW(W)) u_m_uv   (.clk, .en, .a(CW'(ux_r)), .b(vy_r), .p(p_uv));
  ersd_mul #(.AW(CW), .BW(W)) u_m_vu   (.clk, .en, .a(CW'(vx_r)), .b(uy_r), .p(p_vu));
  ersd_mul #(.AW(CW), .BW(W)) u_m_vydx (.clk, .en, .a(dx_r), .b(vy_r), .p(p_vydx));
  ersd_mul #(.AW(CW), .BW(W)) u_m_vxdy (.clk, .en, .a(dy_r), .b(vx_r), .p(p_vxdy));
  ersd_mul #(.AW(CW), .BW(W)) u_m_uxdy (.clk, .en, .a(dy_r), .b(ux_r), .p(p_uxdy));
  ersd_mul #(.AW(CW), .BW(W)) u_m_uydx (.clk, .en, .a(dx_r), .b(uy_r), .p(p_uydx));

  logic signed [QW-1:0] det_nxt, det_r, qx_r, qy_r;
  logic                 det_zero, detz_d;

  assign det_nxt  = QW'(p_uv) - QW'(p_vu);
  assign det_zero = (det_nxt == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= det_nxt;
      qx_r  <= QW'(p_vydx) - QW'(p_vxdy);
      qy_r  <= QW'(p_uxdy) - QW'(p_uydx);
    end
  end

  ersd_dly #(.DW(1), .N(L3 + 2)) u_d_detz (.clk, .en, .d(det_zero), .q(detz_d));

  // Basis held back to meet the unit-space point
  logic [4*W-1:0]      uv_d;
  logic signed [W-1:0] ux_d, uy_d, vx_d, vy_d;

  ersd_dly #(.DW(4*W), .N(L1 + 1)) u_d_uv (
    .clk, .en, .d({ux_r, uy_r, vx_r, vy_r}), .q(uv_d)
  );
  assign ux_d = uv_d[4*W-1:3*W];
  assign uy_d = uv_d[3*W-1:2*W];
  assign vx_d = uv_d[2*W-1:W];
  assign vy_d = uv_d[W-1:0];

  // Gradient products and squares
  localparam int PGW = QW + W;
  logic signed [PGW-1:0]  p_vyqx, p_uyqy, p_uxqy, p_vxqx;
  logic [4*PGW-1:0]       pg_d;
  logic signed [PGW-1:0]  vyqx_d, uyqy_d, uxqy_d, vxqx_d;
  logic signed [2*QW-1:0] sq_qx, sq_qy, sq_det;

  ersd_mul #(.AW(QW), .BW(W))  u_m_vyqx (.clk, .en, .a(qx_r), .b(vy_d), .p(p_vyqx));
  ersd_mul #(.AW(QW), .BW(W))  u_m_uyqy (.clk, .en, .a(qy_r), .b(uy_d), .p(p_uyqy));
  ersd_mul #(.AW(QW), .BW(W))  u_m_uxqy (.clk, .en, .a(qy_r), .b(ux_d), .p(p_uxqy));
  ersd_mul #(.AW(QW), .BW(W))  u_m_vxqx (.clk, .en, .a(qx_r), .b(vx_d), .p(p_vxqx));
  ersd_mul #(.AW(QW), .BW(QW)) u_m_sqx  (.clk, .en, .a(qx_r), .b(qx_r), .p(sq_qx));
  ersd_mul #(.AW(QW), .BW(QW)) u_m_sqy  (.clk, .en, .a(qy_r), .b(qy_r), .p(sq_qy));
  ersd_mul #(.AW(QW), .BW(QW)) u_m_sqd  (.clk, .en, .a(det_r), .b(det_r), .p(sq_det));

  ersd_dly #(.DW(4*PGW), .N(L3 - L1)) u_d_pg (
    .clk, .en, .d({p_vyqx, p_uyqy, p_uxqy, p_vxqx}), .q(pg_d)
  );
  assign vyqx_d = pg_d[4*PGW-1:3*PGW];
  assign uyqy_d = pg_d[3*PGW-1:2*PGW];
  assign uxqy_d = pg_d[2*PGW-1:PGW];
  assign vxqx_d = pg_d[PGW-1:0];

  // Implicit numerator and gradient
  logic signed [GW-1:0] gx_nxt, gy_nxt, gx_r, gy_r;
  logic signed [NW-1:0] num_r, mag;
  logic                 gz_r;

  assign gx_nxt = GW'(vyqx_d) - GW'(uyqy_d);
  assign gy_nxt = GW'(uxqy_d) - GW'(vxqx_d);

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= NW'(sq_qx) + NW'(sq_qy) - NW'(sq_det);
      gx_r  <= gx_nxt;
      gy_r  <= gy_nxt;
      gz_r  <= (gx_nxt == '0) && (gy_nxt == '0);
    end
  end

  // Sign and status; the degenerate basis wins over the centre case
  flag_t fl_now, fl_d;
  logic [FW-1:0] fl_bits;

  assign mag           = num_r[NW-1] ? -num_r : num_r;
  assign fl_now.neg    = num_r[NW-1];
  assign fl_now.status = detz_d ? ST_DEGEN : (gz_r ? ST_CENTRE : ST_OK);

  ersd_dly #(.DW(FW), .N(L4 + 1)) u_d_fl (.clk, .en, .d(fl_now), .q(fl_bits));
  assign fl_d = fl_bits;

  // Squares for the rounding search
  logic signed [M2W-1:0]  mg2;
  logic signed [2*GW-1:0] sq_gx, sq_gy;
  logic [4*GW-1:0]        gsq_d;
  logic [M2W-1:0]         mag2_r;
  logic [GSW-1:0]         gsq_r;

  ersd_mul #(.AW(NW), .BW(NW)) u_m_mag (.clk, .en, .a(mag), .b(mag), .p(mg2));
  ersd_mul #(.AW(GW), .BW(GW)) u_m_gx  (.clk, .en, .a(gx_r), .b(gx_r), .p(sq_gx));
  ersd_mul #(.AW(GW), .BW(GW)) u_m_gy  (.clk, .en, .a(gy_r), .b(gy_r), .p(sq_gy));

  ersd_dly #(.DW(4*GW), .N(L4 - L5)) u_d_gsq (
    .clk, .en, .d({sq_gx, sq_gy}), .q(gsq_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      mag2_r <= mg2;
      gsq_r  <= gsq_d[4*GW-1:2*GW] + gsq_d[2*GW-1:0];
    end
  end

  // Round-half-away division by twice the gradient length, bit by bit
  logic [W-1:0] mag_k;
  flag_t        fl_out;

  ersd_srch #(.W(W), .GSW(GSW), .M2W(M2W)) u_srch (
    .clk, .en, .mag2(mag2_r), .gsq(gsq_r), .flag_i(fl_d), .mag_k(mag_k), .flag_o(fl_out)
  );

  logic signed [W-1:0] dist_nxt;

  assign dist_nxt = (fl_out.status != ST_OK) ? '0 : (fl_out.neg ? -mag_k : mag_k);

  // Output register plus one skid entry
  logic signed [W-1:0] out_dist_r, skid_dist_r;
  status_t             out_st_r, skid_st_r;
  logic                pop, push;

  assign pop  = out_v_r && out_ch.ready;
  assign push = en && vld_r[TOT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r  <= skid_v_r;
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_v_r || pop) begin
        out_dist_r <= dist_nxt;
        out_st_r   <= fl_out.status;
      end else begin
        skid_dist_r <= dist_nxt;
        skid_st_r   <= fl_out.status;
      end
    end else if (pop && skid_v_r) begin
      out_dist_r <= skid_dist_r;
      out_st_r   <= skid_st_r;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.distance = out_dist_r;
  assign out_ch.status   = out_st_r;

endmodule

FILE: test/tb_ellipse_ring_signed_distance_core.sv
import ersd_pkg::*;

localparam int W = COORD_WIDTH_DEF;

typedef logic signed [W-1:0] coord_t;
typedef logic signed [255:0] wide_t;

typedef struct {
  coord_t cx, cy, ux, uy, vx, vy, px, py;
} query_t;

typedef struct {
  coord_t  distance;
  status_t status;
} dist_word_t;

class distance_scoreboard;
  dist_word_t pending_q[$];
  int         errors;

  function new();
    errors = 0;
  endfunction

  // Exact first-order distance, rounded half away from zero, saturated
  function dist_word_t predict_distance(query_t q);
    wide_t ux, uy, vx, vy, dx, dy, det, qx, qy, gx, gy, num, gsq, mag, mag2, t, lhs;
    logic neg;
    longint lo, hi, mid;
    logic [W-1:0] lo_w;
    dist_word_t r;
    ux = q.ux; uy = q.uy; vx = q.vx; vy = q.vy;
    dx = wide_t'(q.px) - wide_t'(q.cx);
    dy = wide_t'(q.py) - wide_t'(q.cy);
    r.distance = '0;
    det = ux * vy - vx * uy;
    if (det == 0) begin
      r.status = ST_DEGEN;
      return r;
    end
    qx = vy * dx - vx * dy;
    qy = ux * dy - uy * dx;
    gx = vy * qx - uy * qy;
    gy = ux * qy - vx * qx;
    if (gx == 0 && gy == 0) begin
      r.status = ST_CENTRE;
      return r;
    end
    num  = qx * qx + qy * qy - det * det;
    gsq  = gx * gx + gy * gy;
    neg  = num < 0;
    mag  = neg ? -num : num;
    mag2 = mag * mag;
    // largest k with (2k-1)^2 |G|^2 <= num^2, capped at the range ends
    lo = 0;
    hi = neg ? (longint'(1) << (W - 1)) : (longint'(1) << (W - 1)) - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t   = wide_t'(2 * mid - 1);
      lhs = t * t * gsq;
      if (lhs <= mag2) lo = mid;
      else hi = mid - 1;
    end
    lo_w = lo[W-1:0];
    r.distance = neg ? -lo_w : lo_w;
    r.status   = ST_OK;
    return r;
  endfunction

  function void note_query(query_t q);
    pending_q.push_back(predict_distance(q));
  endfunction

  function void check_word(coord_t distance, status_t status);
    dist_word_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected word distance=%0d status=%0d", $time, distance, status);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (e.distance !== distance) begin
      $display("%0t: distance mismatch expected=%0d actual=%0d", $time, e.distance, distance);
      errors++;
    end
    if (e.status !== status) begin
      $display("%0t: status mismatch expected=%0d actual=%0d", $time, e.status, status);
      errors++;
    end
  endfunction
endclass

module tb_ellipse_ring_signed_distance_core;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_PER_PHASE = 384;

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   tx_idle_pct;
  int   rx_idle_pct;

  distance_scoreboard sb;

  ersd_in_if  #(.W(W)) in_if();
  ersd_out_if #(.W(W)) out_if();

  ellipse_ring_signed_distance_core #(.COORD_WIDTH(W)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if.sink),
    .out_ch(out_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ellipse_ring_signed_distance_core: FAIL");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Handshakes are sampled mid-cycle, where all signals are settled
  always @(negedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_query('{in_if.centre_x, in_if.centre_y, in_if.major_x, in_if.major_y,
                      in_if.minor_x, in_if.minor_y, in_if.point_x, in_if.point_y});
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_word(out_if.distance, out_if.status);
  end

  task automatic send_query(query_t q);
    logic hs;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.centre_x <= q.cx;
    in_if.centre_y <= q.cy;
    in_if.major_x  <= q.ux;
    in_if.major_y  <= q.uy;
    in_if.minor_x  <= q.vx;
    in_if.minor_y  <= q.vy;
    in_if.point_x  <= q.px;
    in_if.point_y  <= q.py;
    do begin
      @(negedge clk);
      hs = in_if.ready;
      @(posedge clk);
    end while (!hs);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(4))
      0: rand_coord = coord_t'($urandom);
      1: rand_coord = coord_t'($signed($urandom_range(8191)) - 4096);
      2: rand_coord = coord_t'($signed($urandom_range(262143)) - 131072);
      3: rand_coord = $urandom_range(1) ? coord_t'({1'b0, {(W-1){1'b1}}})
                                        : coord_t'({1'b1, {(W-1){1'b0}}});
      default: rand_coord = coord_t'($signed($urandom_range(2047)) - 1024);
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int     k;
    q = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
          rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    k = $urandom_range(19);
    // point near the outline: P = C + U plus a small offset
    if (k < 6) begin
      q.px = q.cx + q.ux + coord_t'($signed($urandom_range(63)) - 32);
      q.py = q.cy + q.uy + coord_t'($signed($urandom_range(63)) - 32);
    end else if (k == 6) begin
      q.px = q.cx; q.py = q.cy;              // point at centre
    end else if (k == 7) begin
      q.vx = q.ux; q.vy = q.uy;              // degenerate basis
    end else if (k == 8) begin
      q.vx = -q.ux; q.vy = -q.uy;            // degenerate, opposite direction
    end else if (k == 9) begin
      q.ux = '0; q.uy = '0;                  // zero basis vector
    end else if (k == 10) begin
      q.vx = coord_t'(q.ux * 2); q.vy = coord_t'(q.uy * 2);
    end
    return q;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_query(rand_query());
  endtask

  localparam coord_t CMAX = {1'b0, {(W-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(W-1){1'b0}}};
  localparam coord_t ONE  = 256;

  initial begin
    query_t dir_q[$];
    sb = new();
    tx_idle_pct = 20;
    rx_idle_pct = 84;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    {in_if.centre_x, in_if.centre_y, in_if.major_x, in_if.major_y} <= '0;
    {in_if.minor_x, in_if.minor_y, in_if.point_x, in_if.point_y} <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unit circle, outline, inside/outside, special cases, extremes
    dir_q.push_back('{0, 0, ONE, 0, 0, ONE, ONE, 0});
    dir_q.push_back('{0, 0, ONE, 0, 0, ONE, 0, 0});
    dir_q.push_back('{0, 0, ONE, 0, 0, ONE, coord_t'(3 * ONE), 0});
    dir_q.push_back('{0, 0, ONE, 0, 0, ONE, ONE / 2, ONE / 3});
    dir_q.push_back('{100, -200, coord_t'(4 * ONE), ONE, -ONE, coord_t'(2 * ONE), 700, 900});
    dir_q.push_back('{0, 0, 0, 0, 0, 0, ONE, ONE});
    dir_q.push_back('{5, 5, ONE, ONE, coord_t'(2 * ONE), coord_t'(2 * ONE), 9, 9});
    dir_q.push_back('{0, 0, 0, 0, 0, 0, 0, 0});
    dir_q.push_back('{7, -7, ONE, 2, 3, ONE, 7, -7});
    dir_q.push_back('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
    dir_q.push_back('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN});
    dir_q.push_back('{CMIN, CMIN, 1, 0, 0, 1, CMAX, CMAX});
    dir_q.push_back('{CMAX, CMAX, 1, 0, 0, -1, CMIN, CMIN});
    dir_q.push_back('{0, 0, CMAX, 0, 0, CMAX, 1, 0});
    dir_q.push_back('{0, 0, CMIN, 0, 0, CMIN, 0, -1});
    dir_q.push_back('{0, 0, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN});
    dir_q.push_back('{CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX});
    dir_q.push_back('{-1, -1, -1, 0, 0, 1, -1, -1});
    dir_q.push_back('{0, 0, 2, 0, 0, 2, 3, 0});
    dir_q.push_back('{0, 0, 2, 0, 0, 2, 1, 0});
    dir_q.push_back('{0, 0, ONE, 0, 0, ONE, -ONE, -ONE});
    foreach (dir_q[i]) send_query(dir_q[i]);

    run_random(RANDOM_PER_PHASE);
    tx_idle_pct = 84;
    rx_idle_pct = 20;
    run_random(RANDOM_PER_PHASE);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);
    in_if.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_ellipse_ring_signed_distance_core: PASS");
    end else begin
      $display("tb_ellipse_ring_signed_distance_core: FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/ersd_pkg.sv
rtl/ersd_if.sv
rtl/ersd_dly.sv
rtl/ersd_mul.sv
rtl/ersd_srch.sv
rtl/ellipse_ring_signed_distance_core.sv
test/tb_ellipse_ring_signed_distance_core.sv
